### rtl/core/gdd_pkg.sv
// Package with the calendar constants and the month table for the day difference block.
`timescale 1ns / 1ps

package gdd_pkg;

    localparam int unsigned DayW    = 5;
    localparam int unsigned MonthW  = 4;
    localparam int unsigned YearW   = 14;
    localparam int unsigned SerialW = 22;
    localparam int unsigned CountW  = 22;

    localparam logic [MonthW-1:0] MonthFirst = 4'd1;
    localparam logic [MonthW-1:0] MonthLast  = 4'd12;
    localparam logic [MonthW-1:0] MonthFeb   = 4'd2;
    localparam logic [YearW-1:0]  YearFirst  = 14'd1;
    localparam logic [YearW-1:0]  YearLast   = 14'd9999;

    // Reciprocal of 25 scaled by 2**17; exact for quotients of values below 2500.
    localparam logic [12:0] Recip25   = 13'd5243;
    localparam int unsigned RecipShift = 17;

    localparam logic [8:0] DaysPerYear = 9'd365;

    function automatic logic [8:0] days_before_month(input logic [MonthW-1:0] month);
        logic [8:0] days;
        begin
            case (month)
                4'd1:    days = 9'd0;
                4'd2:    days = 9'd31;
                4'd3:    days = 9'd59;
                4'd4:    days = 9'd90;
                4'd5:    days = 9'd120;
                4'd6:    days = 9'd151;
                4'd7:    days = 9'd181;
                4'd8:    days = 9'd212;
                4'd9:    days = 9'd243;
                4'd10:   days = 9'd273;
                4'd11:   days = 9'd304;
                4'd12:   days = 9'd334;
                default: days = 9'd0;
            endcase
            return days;
        end
    endfunction

endpackage

### rtl/core/gregorian_day_difference.sv
// Top level: days between two Gregorian dates, one request per cycle while the output is taken.
//
//  Channel   Handshake            Payload
//  input     i_valid / o_ready    i_start_day/month/year, i_end_day/month/year
//  output    o_valid / i_ready    o_day_count, o_end_before_start
//
// Each request passes three register stages: input register, serial number register,
// and result register after the compare and subtract.
// A new request is accepted in every cycle while the output is taken.
// Each stage holds its request while the stage after it is full and stalled, so
// bubbles are absorbed; the input closes only once all three stages hold requests
// and the output is stalled.
// Reset clears the stage valid bits only; the pipeline is empty after reset.
`timescale 1ns / 1ps

module gregorian_day_difference (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [gdd_pkg::DayW-1:0]     i_start_day,
    input  logic [gdd_pkg::MonthW-1:0]   i_start_month,
    input  logic [gdd_pkg::YearW-1:0]    i_start_year,
    input  logic [gdd_pkg::DayW-1:0]     i_end_day,
    input  logic [gdd_pkg::MonthW-1:0]   i_end_month,
    input  logic [gdd_pkg::YearW-1:0]    i_end_year,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [gdd_pkg::CountW-1:0]   o_day_count,
    output logic                         o_end_before_start
);
    import gdd_pkg::*;

    logic                r_in_valid;
    logic [DayW-1:0]     r_start_day;
    logic [MonthW-1:0]   r_start_month;
    logic [YearW-1:0]    r_start_year;
    logic [DayW-1:0]     r_end_day;
    logic [MonthW-1:0]   r_end_month;
    logic [YearW-1:0]    r_end_year;

    logic                r_ser_valid;
    logic [SerialW-1:0]  r_ser_start;
    logic [SerialW-1:0]  r_ser_end;

    logic                r_out_valid;
    logic [CountW-1:0]   r_count;
    logic                r_reversed;

    logic [SerialW-1:0]  n_ser_start;
    logic [SerialW-1:0]  n_ser_end;
    logic [CountW-1:0]   n_count;
    logic                n_reversed;

    logic                out_load;
    logic                ser_load;
    logic                in_load;

    assign out_load = !r_out_valid || i_ready;
    assign ser_load = !r_ser_valid || out_load;
    assign in_load  = !r_in_valid || ser_load;
    assign o_ready  = in_load;

    gdd_serial u_start (
        .i_day    (r_start_day),
        .i_month  (r_start_month),
        .i_year   (r_start_year),
        .o_serial (n_ser_start)
    );

    gdd_serial u_end (
        .i_day    (r_end_day),
        .i_month  (r_end_month),
        .i_year   (r_end_year),
        .o_serial (n_ser_end)
    );

    always_comb begin
        n_reversed = r_ser_end < r_ser_start;
        if (n_reversed) begin
            n_count = '0;
        end else begin
            n_count = CountW'(r_ser_end - r_ser_start);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_ser_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= i_valid;
            end
            if (ser_load) begin
                r_ser_valid <= r_in_valid;
            end
            if (out_load) begin
                r_out_valid <= r_ser_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_valid) begin
            r_start_day   <= i_start_day;
            r_start_month <= i_start_month;
            r_start_year  <= i_start_year;
            r_end_day     <= i_end_day;
            r_end_month   <= i_end_month;
            r_end_year    <= i_end_year;
        end
        if (ser_load && r_in_valid) begin
            r_ser_start <= n_ser_start;
            r_ser_end   <= n_ser_end;
        end
        if (out_load && r_ser_valid) begin
            r_count    <= n_count;
            r_reversed <= n_reversed;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_day_count        = r_count;
    assign o_end_before_start = r_reversed;

endmodule

### rtl/core/gdd_serial.sv
// Combinational day serial number of one Gregorian date.
`timescale 1ns / 1ps

module gdd_serial (
    input  logic [gdd_pkg::DayW-1:0]    i_day,
    input  logic [gdd_pkg::MonthW-1:0]  i_month,
    input  logic [gdd_pkg::YearW-1:0]   i_year,
    output logic [gdd_pkg::SerialW-1:0] o_serial
);
    import gdd_pkg::*;

    logic [MonthW-1:0]  month;
    logic [YearW-1:0]   year;
    logic [YearW-1:0]   prev;
    logic [24:0]        prev_prod;
    logic [7:0]         prev_c100;
    logic [24:0]        year_prod;
    logic [7:0]         year_c100;
    logic [YearW-1:0]   year_rem;
    logic               leap;
    logic [22:0]        year_days;

    always_comb begin
        if (i_month < MonthFirst) begin
            month = MonthFirst;
        end else if (i_month > MonthLast) begin
            month = MonthLast;
        end else begin
            month = i_month;
        end
        if (i_year < YearFirst) begin
            year = YearFirst;
        end else if (i_year > YearLast) begin
            year = YearLast;
        end else begin
            year = i_year;
        end
    end

    // Division by 100 is a shift by two followed by a reciprocal multiply by 1/25.
    assign prev      = year - YearFirst;
    assign prev_prod = 25'(prev[YearW-1:2]) * 25'(Recip25);
    assign prev_c100 = prev_prod[RecipShift+7:RecipShift];
    assign year_prod = 25'(year[YearW-1:2]) * 25'(Recip25);
    assign year_c100 = year_prod[RecipShift+7:RecipShift];
    assign year_rem  = year - YearW'(year_c100) * YearW'(7'd100);

    assign leap = ((year[1:0] == 2'd0) && (year_rem != '0)) ||
                  ((year_rem == '0) && (year_c100[1:0] == 2'd0));

    assign year_days = 23'(prev) * 23'(DaysPerYear);

    always_comb begin
        o_serial = year_days[SerialW-1:0]
                 + SerialW'(prev[YearW-1:2])
                 - SerialW'(prev_c100)
                 + SerialW'(prev_c100[7:2])
                 + SerialW'(days_before_month(month))
                 + SerialW'((month > MonthFeb) && leap)
                 + SerialW'(i_day);
    end

endmodule
